/* sv/aprg_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aprg_pkg: shared types, constants and gamma table builder
// Payload structs, stage enables and the elaboration-time gamma table used by
// the accumulated pixel resolve pipeline.
// ----------------------------------------------------------------------------
package aprg_pkg;

  localparam int FRAC_BITS_DEF        = 16;
  localparam int GAMMA_INDEX_BITS_DEF = 10;
  localparam int GAMMA_INDEX_BITS_MAX = 12;
  localparam int GAMMA_MAX_ENTRIES    = 1 << GAMMA_INDEX_BITS_MAX;

  localparam int SUM_W   = 32;
  localparam int INV_W   = 17;
  localparam int BYTE_W  = 8;
  localparam int PIXEL_W = 24;

  localparam logic [INV_W-1:0] INV_RESET = 17'h10000;

  // Wide enough for (2k+1)^11 * m^5 with k < 256 and m < 4096.
  localparam int BIG_W = 192;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_red;
    logic signed [SUM_W-1:0] sum_green;
    logic signed [SUM_W-1:0] sum_blue;
    logic                    frame_end;
  } in_req_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] packed_pixel;
    logic               frame_end_out;
  } out_req_t;

  typedef struct packed {
    logic mul_en;
    logic idx_en;
    logic rom_en;
  } stage_en_t;

  // Entry i holds round(255 * (i/m)^(5/11)) with ties up, m = 2^index_bits - 1.
  // The byte k is the largest one with ((2k-1)/510)^11 <= (i/m)^5, checked in
  // exact integer arithmetic. Evaluated at elaboration only.
  function automatic logic [BYTE_W*GAMMA_MAX_ENTRIES-1:0] build_gamma(input int index_bits);
    logic [BYTE_W*GAMMA_MAX_ENTRIES-1:0] rom;
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] mpow5;
    int unsigned      m;
    int unsigned      n;
    int unsigned      k;
    int unsigned      i;
    int unsigned      j;
    bit               go;
    rom   = '0;
    n     = 32'd1 << index_bits;
    m     = n - 32'd1;
    k     = 0;
    mpow5 = BIG_W'(1);
    for (j = 0; j < 5; j++) mpow5 = mpow5 * BIG_W'(m);
    for (i = 0; i < n; i++) begin
      rhs = BIG_W'(1);
      for (j = 0; j < 5; j++) rhs = rhs * BIG_W'(i);
      for (j = 0; j < 11; j++) rhs = rhs * BIG_W'(510);
      go = 1'b1;
      while (go) begin
        if (k >= 255) begin
          go = 1'b0;
        end else begin
          lhs = BIG_W'(1);
          for (j = 0; j < 11; j++) lhs = lhs * BIG_W'(2 * k + 1);
          lhs = lhs * mpow5;
          if (lhs <= rhs) k = k + 1;
          else go = 1'b0;
        end
      end
      rom[i*BYTE_W +: BYTE_W] = BYTE_W'(k);
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

/* sv/aprg_rom.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aprg_rom: gamma lookup table
// Constant table of 2^GAMMA_INDEX_BITS bytes with a registered read port.
// ----------------------------------------------------------------------------
module aprg_rom #(
  parameter int GAMMA_INDEX_BITS = aprg_pkg::GAMMA_INDEX_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [GAMMA_INDEX_BITS-1:0] rd_idx,
  output logic      [aprg_pkg::BYTE_W-1:0] rd_data
);

  localparam int ENTRIES = 1 << GAMMA_INDEX_BITS;
  localparam int ROM_W   = aprg_pkg::BYTE_W * ENTRIES;
  localparam logic [ROM_W-1:0] GAMMA_ROM = ROM_W'(aprg_pkg::build_gamma(GAMMA_INDEX_BITS));

  logic [aprg_pkg::BYTE_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data_r <= GAMMA_ROM[{rd_idx, 3'b000} +: aprg_pkg::BYTE_W];
    end
  end

  assign rd_data = data_r;

endmodule
`default_nettype wire

/* sv/aprg_chan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aprg_chan: one color channel lane
// Scales the channel sum, clamps it to [0, 1], forms the table index and
// looks up the gamma corrected byte.
// ----------------------------------------------------------------------------
module aprg_chan #(
  parameter int FRAC_BITS        = aprg_pkg::FRAC_BITS_DEF,
  parameter int GAMMA_INDEX_BITS = aprg_pkg::GAMMA_INDEX_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire aprg_pkg::stage_en_t                en,
  input  wire logic signed [aprg_pkg::SUM_W-1:0]  sum,
  input  wire logic        [aprg_pkg::INV_W-1:0]  inv,
  output logic             [aprg_pkg::BYTE_W-1:0] chan_byte
);

  localparam int PROD_FRAC = FRAC_BITS + 16;
  localparam int PROD_W    = aprg_pkg::SUM_W + aprg_pkg::INV_W;
  localparam int X_W       = PROD_FRAC + 1;
  localparam int SCALED_W  = PROD_FRAC + GAMMA_INDEX_BITS + 1;

  localparam logic [PROD_W-1:0]   ONE_P  = PROD_W'(1) << PROD_FRAC;
  localparam logic [X_W-1:0]      ONE_X  = X_W'(1) << PROD_FRAC;
  localparam logic [SCALED_W-1:0] HALF_S = SCALED_W'(1) << (PROD_FRAC - 1);

  logic signed [PROD_W-1:0]           sum_ext;
  logic signed [PROD_W-1:0]           inv_ext;
  logic        [PROD_W-1:0]           prod_nxt;
  logic        [PROD_W-1:0]           prod_r;
  logic        [X_W-1:0]              x;
  logic        [SCALED_W-1:0]         scaled;
  logic        [GAMMA_INDEX_BITS-1:0] idx_nxt;
  logic        [GAMMA_INDEX_BITS-1:0] idx_r;

  always_comb begin
    sum_ext  = PROD_W'(sum);
    inv_ext  = PROD_W'({1'b0, inv});
    prod_nxt = sum_ext * inv_ext;
  end

  // Clamp to [0, 1], then idx = round(x * (2^G - 1)) using a shift and subtract.
  always_comb begin
    if (prod_r[PROD_W-1] || (prod_r == '0)) begin
      x = '0;
    end else if (prod_r >= ONE_P) begin
      x = ONE_X;
    end else begin
      x = prod_r[X_W-1:0];
    end
    scaled  = (SCALED_W'(x) << GAMMA_INDEX_BITS) - SCALED_W'(x) + HALF_S;
    idx_nxt = scaled[PROD_FRAC+GAMMA_INDEX_BITS-1:PROD_FRAC];
  end

  always_ff @(posedge clk) begin
    if (en.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (en.idx_en) begin
      idx_r <= idx_nxt;
    end
  end

  aprg_rom #(
    .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)
  ) u_rom (
    .clk    (clk),
    .rd_en  (en.rom_en),
    .rd_idx (idx_r),
    .rd_data(chan_byte)
  );

endmodule
`default_nettype wire

/* sv/accumulated_pixel_resolve_gamma.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// accumulated_pixel_resolve_gamma: accumulated pixel resolve with gamma 1/2.2
// Turns summed radiance into a packed 8-bit RGB pixel, one pixel per clock while out_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one request per pixel:
//   three signed channel sums and a last-pixel mark. Output channel (out_valid,
//   out_stall, out_data) returns the packed pixel, red in the low byte, and the
//   mark. cfg_we/cfg_wdata write the reciprocal sample count; write it only
//   while no request is in flight.
//   An accepted request passes a multiply stage, a clamp and index stage,
//   and the gamma table read, whose registered data is the output register.
//   Throughput is one request per cycle while out_stall is low; each lane
//   has its own multiplier and table copy, so all three channels run in
//   parallel.
//   Reset clears all stage valids and sets the sample count reciprocal to one
//   sample. When the receiver stalls, the output holds; empty stages further
//   up keep filling, and in_stall rises only once every stage holds a request.
// ----------------------------------------------------------------------------
module accumulated_pixel_resolve_gamma #(
  parameter int FRAC_BITS        = aprg_pkg::FRAC_BITS_DEF,
  parameter int GAMMA_INDEX_BITS = aprg_pkg::GAMMA_INDEX_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire aprg_pkg::in_req_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output aprg_pkg::out_req_t                out_data,
  input  wire logic                         cfg_we,
  input  wire logic [aprg_pkg::INV_W-1:0]   cfg_wdata
);

  logic [aprg_pkg::INV_W-1:0]  inv_r;
  logic                        v1_r;
  logic                        v2_r;
  logic                        v3_r;
  logic                        fe1_r;
  logic                        fe2_r;
  logic                        fe3_r;
  logic                        adv1;
  logic                        adv2;
  logic                        adv3;
  aprg_pkg::stage_en_t         en;
  logic [aprg_pkg::BYTE_W-1:0] red_byte;
  logic [aprg_pkg::BYTE_W-1:0] green_byte;
  logic [aprg_pkg::BYTE_W-1:0] blue_byte;

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    adv3      = !v3_r || !out_stall;
    adv2      = !v2_r || adv3;
    adv1      = !v1_r || adv2;
    en.mul_en = adv1;
    en.idx_en = adv2;
    en.rom_en = adv3;
  end

  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= aprg_pkg::INV_RESET;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        inv_r <= cfg_wdata;
      end
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      fe1_r <= in_data.frame_end;
    end
    if (adv2) begin
      fe2_r <= fe1_r;
    end
    if (adv3) begin
      fe3_r <= fe2_r;
    end
  end

  aprg_chan #(
    .FRAC_BITS       (FRAC_BITS),
    .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)
  ) u_chan_red (
    .clk      (clk),
    .en       (en),
    .sum      (in_data.sum_red),
    .inv      (inv_r),
    .chan_byte(red_byte)
  );

  aprg_chan #(
    .FRAC_BITS       (FRAC_BITS),
    .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)
  ) u_chan_green (
    .clk      (clk),
    .en       (en),
    .sum      (in_data.sum_green),
    .inv      (inv_r),
    .chan_byte(green_byte)
  );

  aprg_chan #(
    .FRAC_BITS       (FRAC_BITS),
    .GAMMA_INDEX_BITS(GAMMA_INDEX_BITS)
  ) u_chan_blue (
    .clk      (clk),
    .en       (en),
    .sum      (in_data.sum_blue),
    .inv      (inv_r),
    .chan_byte(blue_byte)
  );

  assign out_valid              = v3_r;
  assign out_data.packed_pixel  = {blue_byte, green_byte, red_byte};
  assign out_data.frame_end_out = fe3_r;

`ifndef SYNTHESIS
  // Input is held back only when every stage is occupied.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r))
    else $error("in_stall raised with an empty pipeline stage");

  // An accepted request always lands in the first stage.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted request lost at the multiply stage");

  // A request in the index stage reaches the output when the output is free.
  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !out_stall) |=> out_valid)
    else $error("request dropped between index stage and output");
`endif

endmodule
`default_nettype wire
